// ===== hdl/gtpt_pkg.sv =====
// ----------------------------------------------------------------------------
// gtpt_pkg
// Shared types and constants for the generation tagged probe table.
// ----------------------------------------------------------------------------
package gtpt_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int PROBE_LIMIT = 16;
  localparam int TABLE_SIZE  = 1 << INDEX_BITS;
  localparam int CNT_W       = $clog2(PROBE_LIMIT + 1);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [31:0] W_POS_MAX = 32'h7F80_0000;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_COPY  = 2'd1;
  localparam logic [1:0] MODE_LOOK  = 2'd2;
  localparam logic [1:0] MODE_ADV   = 2'd3;

  typedef logic [INDEX_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_addr;
    logic [31:0] src_addr;
    logic [31:0] word_value;
    logic [31:0] src_word;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] w_bits;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_w;
  } res_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] gen;
    logic [31:0] word;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
  } slot_t;

  typedef struct packed {
    logic key_match;
    logic empty;
    logic current;
  } probe_flags_t;

  // low INDEX_BITS of (key >> 2) * HASH_MULT only depend on the low bits
  function automatic slot_idx_t home_slot(input logic [31:0] key);
    logic [2*INDEX_BITS-1:0] prod;
    prod = (2*INDEX_BITS)'(key[INDEX_BITS+1:2]) *
           (2*INDEX_BITS)'(HASH_MULT[INDEX_BITS-1:0]);
    return prod[INDEX_BITS-1:0];
  endfunction

  function automatic logic w_positive(input logic [31:0] b);
    return !b[31] && (b != 32'd0) && (b <= W_POS_MAX);
  endfunction

endpackage

// ===== hdl/gtpt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// gtpt_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gtpt_slot_ram import gtpt_pkg::*; (
  input  logic      clk,
  input  logic      we,
  input  slot_idx_t waddr,
  input  slot_t     wdata,
  input  slot_idx_t raddr,
  output slot_t     rdata
);

  slot_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gtpt_probe_unit.sv =====
// ----------------------------------------------------------------------------
// gtpt_probe_unit
// Slot compare unit shared by every probe of get and put.
// ----------------------------------------------------------------------------
module gtpt_probe_unit import gtpt_pkg::*; (
  input  slot_t        slot,
  input  logic [31:0]  target,
  input  logic [31:0]  cur_gen,
  output probe_flags_t flags
);

  assign flags.key_match = (slot.key == target);
  assign flags.empty     = (slot.key == 32'd0);
  assign flags.current   = (slot.gen == cur_gen);

endmodule

// ===== hdl/gtpt_seq.sv =====
// ----------------------------------------------------------------------------
// gtpt_seq
// Sequencer: clear pass, hashing, probe walk over the slot RAM, slot write.
// ----------------------------------------------------------------------------
module gtpt_seq import gtpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cmd_t      cmd,
  input  logic      enable,
  output logic      busy,
  output logic      done,
  output res_t      res,
  output logic      ram_we,
  output slot_idx_t ram_waddr,
  output slot_t     ram_wdata,
  output slot_idx_t ram_raddr,
  input  slot_t     ram_rdata
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_HASH = 5'b00100,
    S_PRB  = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

  state_t       state;
  cmd_t         item;
  logic [31:0]  cur_gen;
  logic         ph_get;
  slot_idx_t    home;
  logic [CNT_W-1:0] cnt;
  logic         dv;
  logic         last;
  slot_idx_t    prv_addr;
  slot_idx_t    wr_addr;
  slot_idx_t    clr_addr;
  logic [31:0]  pl_x;
  logic [31:0]  pl_y;
  logic [31:0]  pl_w;

  logic [31:0]  tgt_key;
  probe_flags_t flags;
  logic         get_end;
  logic         found;
  logic         put_hit;
  res_t         look_res;

  assign tgt_key = (ph_get && item.mode == MODE_COPY) ? item.src_addr : item.key_addr;

  gtpt_probe_unit u_probe (
    .slot    (ram_rdata),
    .target  (tgt_key),
    .cur_gen (cur_gen),
    .flags   (flags)
  );

  assign get_end = flags.key_match || flags.empty || last;
  assign found   = flags.key_match && flags.current;
  assign put_hit = flags.key_match || flags.empty || !flags.current;

  always_comb begin
    look_res = '0;
    if (found && ram_rdata.word == item.word_value && w_positive(ram_rdata.w)) begin
      look_res.hit   = 1'b1;
      look_res.out_x = ram_rdata.x;
      look_res.out_y = ram_rdata.y;
      look_res.out_w = ram_rdata.w;
    end
  end

  assign busy      = (state != S_IDLE);
  assign ram_raddr = home + slot_idx_t'(cnt);
  assign ram_we    = (state == S_CLR) || (state == S_WR);
  assign ram_waddr = (state == S_CLR) ? clr_addr : wr_addr;
  assign ram_wdata = (state == S_CLR) ? slot_t'('0)
                   : {item.key_addr, cur_gen, item.word_value, pl_x, pl_y, pl_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cur_gen  <= 32'd1;
      clr_addr <= '0;
      dv       <= 1'b0;
      done     <= 1'b0;
      res      <= '0;
    end else begin
      done <= 1'b0;
      res  <= '0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item <= cmd;
            pl_x <= cmd.x_bits;
            pl_y <= cmd.y_bits;
            pl_w <= cmd.w_bits;
            unique case (cmd.mode)
              MODE_ADV: begin
                cur_gen <= cur_gen + 32'd1;
                done    <= 1'b1;
              end
              MODE_COPY: begin
                ph_get <= 1'b1;
                if (enable) begin
                  state <= S_HASH;
                end else begin
                  done <= 1'b1;
                end
              end
              MODE_LOOK: begin
                ph_get <= 1'b1;
                state  <= S_HASH;
              end
              MODE_STORE: begin
                ph_get <= 1'b0;
                state  <= S_HASH;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_HASH: begin
          home  <= home_slot(tgt_key);
          cnt   <= '0;
          dv    <= 1'b0;
          state <= S_PRB;
        end
        S_PRB: begin
          // one read issued per cycle, data checked the cycle after
          cnt      <= cnt + 1'b1;
          dv       <= 1'b1;
          prv_addr <= ram_raddr;
          last     <= (cnt == CNT_W'(PROBE_LIMIT - 1));
          if (dv) begin
            if (ph_get) begin
              if (get_end) begin
                if (item.mode == MODE_LOOK) begin
                  res   <= look_res;
                  done  <= 1'b1;
                  state <= S_IDLE;
                end else if (found && ram_rdata.word == item.src_word) begin
                  // source payload latched before the put may overwrite it
                  pl_x   <= ram_rdata.x;
                  pl_y   <= ram_rdata.y;
                  pl_w   <= ram_rdata.w;
                  ph_get <= 1'b0;
                  state  <= S_HASH;
                end else begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end
              end
            end else if (put_hit) begin
              wr_addr <= prv_addr;
              state   <= S_WR;
            end else if (last) begin
              wr_addr <= home;
              state   <= S_WR;
            end
          end
        end
        S_WR: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");

  a_res_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> res == '0)
    else $error("result bits set without strobe");

  a_hit_wpos: assert property (@(posedge clk) disable iff (rst)
    res.hit |-> (!res.out_w[31] && res.out_w != 32'd0))
    else $error("hit with non-positive w");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_WR))
    else $error("slot write outside clear or write step");

  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> busy)
    else $error("ready during clear pass");

endmodule

// ===== hdl/generation_tagged_probe_table.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_probe_table
// Open-addressed slot table with linear probing and generation tags.
// ----------------------------------------------------------------------------
// Advance and disabled copy finish from idle; lookup hashes and walks the probe
//   window; store also writes a slot; copy walks for the source, then stores.
// Probe walk: one slot RAM read per cycle, each checked in the cycle after.
// One word in flight; the next start is taken at the edge that ends the
//   done cycle.
// Reset: synchronous; a clearing pass then zeroes every slot, with busy high.
module generation_tagged_probe_table import gtpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic      enable;
  logic      ram_we;
  slot_idx_t ram_waddr;
  slot_t     ram_wdata;
  slot_idx_t ram_raddr;
  slot_t     ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  gtpt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .enable    (enable),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  gtpt_slot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== tb/gtpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpt_checker
// Watches the command, result and enable channels of the probe table. It keeps
// its own copy of the slot table, generation and enable bit, works out the
// result of every accepted command and compares the results in order.
// ----------------------------------------------------------------------------
module gtpt_checker import gtpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd,
  input  logic done,
  input  res_t res,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  output int   errors,
  output int   open_words
);

  slot_t       slots [TABLE_SIZE];
  logic [31:0] gen_now;
  logic        copy_en;
  res_t        owed_results [$];
  int          mismatch_count = 0;

  assign errors = mismatch_count;

  function automatic slot_idx_t hash_home(input logic [31:0] key);
    logic [31:0] prod;
    prod = (key >> 2) * HASH_MULT;
    return prod[INDEX_BITS-1:0];
  endfunction

  // sign clear and nonzero, and no bigger than +inf
  function automatic logic w_is_positive(input logic [31:0] b);
    return ($signed(b) > 0) && (b <= 32'h7F80_0000);
  endfunction

  function automatic void put_entry(input logic [31:0] key, input logic [31:0] word,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] w);
    slot_idx_t h;
    slot_idx_t s;
    logic      placed;
    h = hash_home(key);
    s = h;
    placed = 1'b0;
    for (int i = 0; i < PROBE_LIMIT && !placed; i++) begin
      s = h + slot_idx_t'(i);
      if (slots[s].key == key || slots[s].key == 32'd0 || slots[s].gen != gen_now)
        placed = 1'b1;
    end
    // window full: the home slot is taken over
    if (!placed)
      s = h;
    slots[s] = {key, gen_now, word, x, y, w};
  endfunction

  function automatic logic find_entry(input logic [31:0] key, output slot_idx_t at);
    slot_idx_t h;
    slot_idx_t s;
    logic      stop;
    logic      found;
    h = hash_home(key);
    at = h;
    stop = 1'b0;
    found = 1'b0;
    for (int i = 0; i < PROBE_LIMIT && !stop; i++) begin
      s = h + slot_idx_t'(i);
      if (slots[s].key == key) begin
        stop = 1'b1;
        found = (slots[s].gen == gen_now);
        at = s;
      end else if (slots[s].key == 32'd0) begin
        stop = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic res_t predict_result(input cmd_t c);
    res_t      r;
    slot_idx_t s;
    slot_t     e;
    r = '0;
    case (c.mode)
      MODE_STORE: begin
        put_entry(c.key_addr, c.word_value, c.x_bits, c.y_bits, c.w_bits);
      end
      MODE_COPY: begin
        if (copy_en) begin
          if (find_entry(c.src_addr, s)) begin
            // payload is taken before the put, which may land on the source slot
            e = slots[s];
            if (e.word == c.src_word)
              put_entry(c.key_addr, c.word_value, e.x, e.y, e.w);
          end
        end
      end
      MODE_LOOK: begin
        if (find_entry(c.key_addr, s)) begin
          e = slots[s];
          if (e.word == c.word_value && w_is_positive(e.w))
            r = {1'b1, e.x, e.y, e.w};
        end
      end
      default: begin
        gen_now = gen_now + 32'd1;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++)
        slots[i] = '0;
      gen_now = 32'd1;
      copy_en = 1'b0;
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none actual %h", $time, res);
        end else begin
          want = owed_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(res.hit));
          check_field("out_x", want.out_x, res.out_x);
          check_field("out_y", want.out_y, res.out_y);
          check_field("out_w", want.out_w, res.out_w);
        end
      end
      // a word taken at this edge still sees the old enable bit
      if (start && !busy)
        owed_results.push_back(predict_result(cmd));
      if (cfg_valid && cfg_ready)
        copy_en = cfg_data;
    end
    open_words <= owed_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the generation tagged probe table: a directed pass over the
// special cases, then phases of random commands over a key pool built with
// crowded home slots, with bursts of idle cycles and enable changes between
// phases. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb;
  import gtpt_pkg::*;

  localparam int POOL_N   = 40;
  localparam int CLUS_A_N = 24;
  localparam int CLUS_B_N = 8;
  localparam int PHASES   = 6;
  localparam int RAND_N   = 250;

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  res_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  int   errors;
  int   open_words;

  logic [31:0] key_pool  [POOL_N];
  logic [31:0] word_pool [POOL_N];
  logic        idle_on;

  always #1 clk = ~clk;

  generation_tagged_probe_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gtpt_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .open_words (open_words)
  );

  function automatic logic [31:0] pick_w();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000 | $urandom();
      2: return 32'h7F80_0000;
      3: return 32'h7F80_0001 + $urandom_range(0, 1000);
      4: return 32'h7F7F_FFFF;
      5: return 32'h0000_0001;
      6: return 32'h8000_0000;
      default: return $urandom_range(32'h7F7F_FFFF, 1);
    endcase
  endfunction

  // clusters of keys sharing a home slot keep the probe window busy
  function automatic int pick_key_idx();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return $urandom_range(1, CLUS_A_N);
    else if (r < 65)
      return $urandom_range(CLUS_A_N + 1, CLUS_A_N + CLUS_B_N);
    return $urandom_range(0, POOL_N - 1);
  endfunction

  function automatic cmd_t rand_cmd(input int adv_pct);
    cmd_t c;
    int   r;
    int   ki;
    int   si;
    c.mode       = 2'($urandom_range(0, 3));
    c.key_addr   = $urandom();
    c.src_addr   = $urandom();
    c.word_value = $urandom();
    c.src_word   = $urandom();
    c.x_bits     = $urandom();
    c.y_bits     = $urandom();
    c.w_bits     = $urandom();
    r  = $urandom_range(0, 99);
    ki = pick_key_idx();
    si = pick_key_idx();
    if (r < 4) begin
      // raw noise
    end else if (r < 4 + adv_pct) begin
      c.mode = MODE_ADV;
    end else if (r < 45) begin
      c.mode = MODE_STORE;
      if ($urandom_range(0, 9) != 0)
        c.key_addr = key_pool[ki];
      if ($urandom_range(0, 2) == 0)
        word_pool[ki] = $urandom();
      c.word_value = word_pool[ki];
      c.w_bits = pick_w();
    end else if (r < 62) begin
      c.mode = MODE_COPY;
      c.src_addr = key_pool[si];
      if ($urandom_range(0, 4) != 0)
        c.src_word = word_pool[si];
      c.key_addr = key_pool[ki];
      if ($urandom_range(0, 3) != 0)
        c.word_value = word_pool[ki];
      word_pool[ki] = c.word_value;
    end else begin
      c.mode = MODE_LOOK;
      c.key_addr = key_pool[ki];
      if ($urandom_range(0, 6) != 0)
        c.word_value = word_pool[ki];
    end
    return c;
  endfunction

  task automatic send_word(input cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(input logic [1:0] mode, input logic [31:0] key,
                       input logic [31:0] src, input logic [31:0] word,
                       input logic [31:0] sword, input logic [31:0] x,
                       input logic [31:0] y, input logic [31:0] w);
    cmd_t c;
    c = {mode, key, src, word, sword, x, y, w};
    send_word(c);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (open_words != 0 || busy) @(posedge clk);
  endtask

  task automatic set_enable(input logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] r;
    logic [11:0] home_a;
    logic [11:0] home_b;
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    idle_on = 1'b1;

    home_a = 12'($urandom());
    home_b = 12'($urandom());
    key_pool[0] = 32'd0;
    for (int i = 1; i < POOL_N; i++) begin
      r = $urandom();
      if (i <= CLUS_A_N)
        key_pool[i] = {r[31:14], home_a, r[1:0]};
      else if (i <= CLUS_A_N + CLUS_B_N)
        key_pool[i] = {r[31:14], home_b, r[1:0]};
      else
        key_pool[i] = r;
    end
    for (int i = 0; i < POOL_N; i++)
      word_pool[i] = $urandom();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed, copy disabled first
    set_enable(1'b0);
    // address zero hits the first empty slot, whose w is zero
    issue(MODE_LOOK,  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'h0, 32'h0, 32'h5, 32'h0, 32'h1234_5678, 32'hDEAD_BEEF,
          32'h3F80_0000);
    issue(MODE_LOOK,  32'h0, 32'h0, 32'h5, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'h0, 32'h7F80_0000);
    issue(MODE_LOOK,  32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_COPY,  32'h100, 32'hFFFF_FFFF, 32'h7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h100, 32'h0, 32'h7, 32'h0, 32'h0, 32'h0, 32'h0);

    set_enable(1'b1);
    issue(MODE_COPY,  32'h100, 32'hFFFF_FFFF, 32'h7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h100, 32'h0, 32'h7, 32'h0, 32'h0, 32'h0, 32'h0);
    // source word mismatch does nothing
    issue(MODE_COPY,  32'h104, 32'h100, 32'h8, 32'h6, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h104, 32'h0, 32'h8, 32'h0, 32'h0, 32'h0, 32'h0);
    // copy onto its own source slot
    issue(MODE_COPY,  32'h100, 32'h100, 32'h9, 32'h7, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h100, 32'h0, 32'h9, 32'h0, 32'h0, 32'h0, 32'h0);
    // w zero, negative, NaN miss; smallest denormal hits
    issue(MODE_STORE, 32'h200, 32'h0, 32'h1, 32'h0, 32'h11, 32'h22, 32'h0);
    issue(MODE_LOOK,  32'h200, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'h204, 32'h0, 32'h1, 32'h0, 32'h11, 32'h22, 32'h8000_0001);
    issue(MODE_LOOK,  32'h204, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'h208, 32'h0, 32'h1, 32'h0, 32'h11, 32'h22, 32'h7F80_0001);
    issue(MODE_LOOK,  32'h208, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'h20C, 32'h0, 32'h1, 32'h0, 32'h11, 32'h22, 32'h0000_0001);
    issue(MODE_LOOK,  32'h20C, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h20C, 32'h0, 32'h2, 32'h0, 32'h0, 32'h0, 32'h0);
    // entry goes stale after advance, then the stale slot is reused
    issue(MODE_ADV,   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_LOOK,  32'h20C, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(MODE_STORE, 32'h20C, 32'h0, 32'h1, 32'h0, 32'h33, 32'h44, 32'h4000_0000);
    issue(MODE_LOOK,  32'h20C, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      set_enable((p % 3) != 1);
      idle_on = (p != PHASES - 1);
      if (p % 2 == 1)
        issue(MODE_ADV, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom());
      // fill the crowded home past the probe window
      for (int i = 1; i <= CLUS_A_N; i++)
        issue(MODE_STORE, key_pool[i], $urandom(), word_pool[i], $urandom(), $urandom(),
              $urandom(), $urandom_range(32'h7F7F_FFFF, 1));
      repeat (RAND_N) send_word(rand_cmd((p < 2) ? 0 : p));
    end

    wait_idle();
    repeat (2 * PROBE_LIMIT + 8) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gtpt_pkg.sv
hdl/gtpt_slot_ram.sv
hdl/gtpt_probe_unit.sv
hdl/gtpt_seq.sv
hdl/generation_tagged_probe_table.sv
tb/gtpt_checker.sv
tb/tb.sv
